/* hdl/assert_macros.svh */
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_HOLDS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/pfc_pkg.sv */
package pfc_pkg;

  localparam int LETTER_W    = 5;
  localparam int CELLS       = 25;
  localparam int SIDE        = 5;
  localparam int ALPHABET    = 26;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [4:0]          cell_t;
  typedef logic [2:0]          coord_t;
  typedef logic [2:0]          opcode_t;

  localparam letter_t LETTER_I = letter_t'(8);
  localparam letter_t LETTER_J = letter_t'(9);
  localparam letter_t LETTER_Z = letter_t'(25);

  localparam opcode_t OPC_CLEAR   = opcode_t'(0);
  localparam opcode_t OPC_KEY     = opcode_t'(1);
  localparam opcode_t OPC_FINISH  = opcode_t'(2);
  localparam opcode_t OPC_ENCRYPT = opcode_t'(3);
  localparam opcode_t OPC_DECRYPT = opcode_t'(4);

  typedef enum logic [2:0] {
    CMD_CLEAR,
    CMD_KEY,
    CMD_FINISH,
    CMD_ENCRYPT,
    CMD_DECRYPT,
    CMD_NOP
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POS,
    ST_CELL,
    ST_FILL
  } back_state_t;

  typedef struct packed {
    opcode_t opcode;
    letter_t first_letter;
    letter_t second_letter;
  } in_word_t;

  typedef struct packed {
    letter_t first_out;
    letter_t second_out;
    logic    status;
  } out_word_t;

  typedef struct packed {
    cmd_t    cmd;
    letter_t first;
    letter_t second;
  } item_t;

  function automatic letter_t norm_letter(input letter_t raw);
    letter_t v;
    v = (raw > LETTER_Z) ? LETTER_Z : raw;
    if (v == LETTER_J) begin
      v = LETTER_I;
    end
    return v;
  endfunction

  function automatic coord_t pos_row(input cell_t p);
    coord_t r;
    if (p >= cell_t'(4*SIDE)) begin
      r = coord_t'(4);
    end else if (p >= cell_t'(3*SIDE)) begin
      r = coord_t'(3);
    end else if (p >= cell_t'(2*SIDE)) begin
      r = coord_t'(2);
    end else if (p >= cell_t'(SIDE)) begin
      r = coord_t'(1);
    end else begin
      r = coord_t'(0);
    end
    return r;
  endfunction

  function automatic cell_t cell_index(input coord_t row, input coord_t col);
    return (cell_t'(row) << 2) + cell_t'(row) + cell_t'(col);
  endfunction

  function automatic coord_t pos_col(input cell_t p);
    cell_t base;
    base = cell_index(pos_row(p), coord_t'(0));
    return coord_t'(p - base);
  endfunction

  function automatic coord_t coord_step(input coord_t c, input logic back);
    coord_t r;
    if (back) begin
      r = (c == coord_t'(0)) ? coord_t'(SIDE-1) : c - coord_t'(1);
    end else begin
      r = (c == coord_t'(SIDE-1)) ? coord_t'(0) : c + coord_t'(1);
    end
    return r;
  endfunction

endpackage

/* hdl/pfc_front.sv */
module pfc_front (
  input  logic             start,
  input  logic             q_full,
  input  pfc_pkg::in_word_t in_data,
  output logic             push,
  output pfc_pkg::item_t   push_item
);

  always_comb begin
    push             = start & ~q_full;
    push_item.first  = pfc_pkg::norm_letter(in_data.first_letter);
    push_item.second = pfc_pkg::norm_letter(in_data.second_letter);
    unique case (in_data.opcode)
      pfc_pkg::OPC_CLEAR:   push_item.cmd = pfc_pkg::CMD_CLEAR;
      pfc_pkg::OPC_KEY:     push_item.cmd = pfc_pkg::CMD_KEY;
      pfc_pkg::OPC_FINISH:  push_item.cmd = pfc_pkg::CMD_FINISH;
      pfc_pkg::OPC_ENCRYPT: push_item.cmd = pfc_pkg::CMD_ENCRYPT;
      pfc_pkg::OPC_DECRYPT: push_item.cmd = pfc_pkg::CMD_DECRYPT;
      default:              push_item.cmd = pfc_pkg::CMD_NOP;
    endcase
  end

endmodule

/* hdl/pfc_queue.sv */
`include "assert_macros.svh"

module pfc_queue #(
  parameter int DEPTH = pfc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pfc_pkg::item_t push_item,
  input  logic           pop,
  output pfc_pkg::item_t pop_item,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pfc_pkg::item_t   store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    full       = (count_r == CNT_W'(DEPTH));
    empty      = (count_r == '0);
    pop_item   = store_r[rd_ptr_r];
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

  `ASSERT_HOLDS(a_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH), "queue count overflow")
  `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, pop, !empty, "pop from empty queue")

endmodule

/* hdl/pfc_back.sv */
`include "assert_macros.svh"

module pfc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  pfc_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               out_strobe,
  output pfc_pkg::out_word_t out_data
);

  pfc_pkg::back_state_t state_r, state_nxt;
  logic [pfc_pkg::ALPHABET-1:0] present_r, present_nxt;
  pfc_pkg::cell_t   fill_r, fill_nxt;
  logic             ready_r, ready_nxt;
  pfc_pkg::letter_t ch_r, ch_nxt;
  logic             decrypt_r, decrypt_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  pfc_pkg::out_word_t out_data_r, out_data_nxt;

  pfc_pkg::letter_t key_mem [pfc_pkg::CELLS];
  pfc_pkg::cell_t   pos_mem [pfc_pkg::ALPHABET];
  pfc_pkg::cell_t   pos1_q, pos2_q;
  pfc_pkg::letter_t key1_q, key2_q;

  logic             wr_en;
  pfc_pkg::letter_t cand;
  logic             can_place;
  logic             pos_rd_en, key_rd_en;
  pfc_pkg::cell_t   key_rd_a, key_rd_b;
  pfc_pkg::coord_t  r1, c1, r2, c2;

  always_comb begin
    state_nxt      = state_r;
    present_nxt    = present_r;
    fill_nxt       = fill_r;
    ready_nxt      = ready_r;
    ch_nxt         = ch_r;
    decrypt_nxt    = decrypt_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    q_pop          = 1'b0;
    wr_en          = 1'b0;
    pos_rd_en      = 1'b0;
    key_rd_en      = 1'b0;
    key_rd_a       = '0;
    key_rd_b       = '0;
    cand           = (state_r == pfc_pkg::ST_FILL) ? ch_r : q_item.first;
    can_place      = !present_r[cand] && (fill_r < pfc_pkg::cell_t'(pfc_pkg::CELLS));
    r1             = pfc_pkg::pos_row(pos1_q);
    c1             = pfc_pkg::pos_col(pos1_q);
    r2             = pfc_pkg::pos_row(pos2_q);
    c2             = pfc_pkg::pos_col(pos2_q);

    unique case (state_r)
      pfc_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_item.cmd) inside
            pfc_pkg::CMD_CLEAR: begin
              present_nxt    = '0;
              fill_nxt       = '0;
              ready_nxt      = 1'b0;
              out_strobe_nxt = 1'b1;
              out_data_nxt   = '0;
            end
            pfc_pkg::CMD_KEY: begin
              wr_en          = !ready_r && can_place;
              out_strobe_nxt = 1'b1;
              out_data_nxt   = '0;
            end
            pfc_pkg::CMD_FINISH: begin
              ch_nxt    = '0;
              state_nxt = pfc_pkg::ST_FILL;
            end
            pfc_pkg::CMD_ENCRYPT, pfc_pkg::CMD_DECRYPT: begin
              if (!ready_r) begin
                out_strobe_nxt      = 1'b1;
                out_data_nxt        = '0;
                out_data_nxt.status = 1'b1;
              end else begin
                pos_rd_en   = 1'b1;
                decrypt_nxt = (q_item.cmd == pfc_pkg::CMD_DECRYPT);
                state_nxt   = pfc_pkg::ST_POS;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
              out_data_nxt   = '0;
            end
          endcase
        end
      end
      pfc_pkg::ST_POS: begin
        key_rd_en = 1'b1;
        if (r1 == r2) begin
          key_rd_a = pfc_pkg::cell_index(r1, pfc_pkg::coord_step(c1, decrypt_r));
          key_rd_b = pfc_pkg::cell_index(r2, pfc_pkg::coord_step(c2, decrypt_r));
        end else if (c1 == c2) begin
          key_rd_a = pfc_pkg::cell_index(pfc_pkg::coord_step(r1, decrypt_r), c1);
          key_rd_b = pfc_pkg::cell_index(pfc_pkg::coord_step(r2, decrypt_r), c2);
        end else begin
          key_rd_a = pfc_pkg::cell_index(r1, c2);
          key_rd_b = pfc_pkg::cell_index(r2, c1);
        end
        state_nxt = pfc_pkg::ST_CELL;
      end
      pfc_pkg::ST_CELL: begin
        out_strobe_nxt          = 1'b1;
        out_data_nxt.first_out  = key1_q;
        out_data_nxt.second_out = key2_q;
        out_data_nxt.status     = 1'b0;
        state_nxt               = pfc_pkg::ST_IDLE;
      end
      pfc_pkg::ST_FILL: begin
        wr_en = (ch_r != pfc_pkg::LETTER_J) && can_place;
        if (ch_r == pfc_pkg::LETTER_Z) begin
          ready_nxt      = 1'b1;
          out_strobe_nxt = 1'b1;
          out_data_nxt   = '0;
          state_nxt      = pfc_pkg::ST_IDLE;
        end else begin
          ch_nxt = ch_r + pfc_pkg::letter_t'(1);
        end
      end
      default: state_nxt = pfc_pkg::ST_IDLE;
    endcase

    if (wr_en) begin
      present_nxt[cand] = 1'b1;
      fill_nxt          = fill_r + pfc_pkg::cell_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pfc_pkg::ST_IDLE;
      present_r    <= '0;
      fill_r       <= '0;
      ready_r      <= 1'b0;
      ch_r         <= '0;
      decrypt_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      present_r    <= present_nxt;
      fill_r       <= fill_nxt;
      ready_r      <= ready_nxt;
      ch_r         <= ch_nxt;
      decrypt_r    <= decrypt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (wr_en) begin
      key_mem[fill_r] <= cand;
      pos_mem[cand]   <= fill_r;
    end
    if (pos_rd_en) begin
      pos1_q <= pos_mem[q_item.first];
      pos2_q <= pos_mem[q_item.second];
    end
    if (key_rd_en) begin
      key1_q <= key_mem[key_rd_a];
      key2_q <= key_mem[key_rd_b];
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  `ASSERT_HOLDS(a_fill_bound, clk, rst_n, fill_r <= pfc_pkg::cell_t'(pfc_pkg::CELLS), "fill overflow")
  `ASSERT_IMPLIES(a_ready_full, clk, rst_n, ready_r, fill_r == pfc_pkg::cell_t'(pfc_pkg::CELLS), "ready with square not full")
  `ASSERT_IMPLIES(a_status_not_ready, clk, rst_n, out_strobe_r && out_data_r.status, !ready_r, "status word while square ready")
  `ASSERT_NEXT(a_cell_emits, clk, rst_n, state_r == pfc_pkg::ST_CELL, out_strobe_r, "pair result not emitted")

endmodule

/* hdl/playfair_digraph_cipher_top.sv */
// the back-end sequencer pops a queued word only in idle and answers clear, key letter
// and unused opcodes from idle, a pair after position and key reads, finish after the fill
// walk (one letter of the alphabet a cycle); the queue keeps taking words meanwhile;
// busy rises while the command queue is full, the result side never stalls
// reset: synchronous, active low; clears sequencer, queue, present flags, fill count
// and ready flag; square and position memories are not cleared
module playfair_digraph_cipher_top #(
  parameter int QUEUE_DEPTH = pfc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  pfc_pkg::in_word_t  in_data,
  output logic               busy,
  output logic               out_strobe,
  output pfc_pkg::out_word_t out_data
);

  logic           push, pop, q_full, q_empty;
  pfc_pkg::item_t push_item, pop_item;

  pfc_front u_front (
    .start     (start),
    .q_full    (q_full),
    .in_data   (in_data),
    .push      (push),
    .push_item (push_item)
  );

  pfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  pfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_item     (pop_item),
    .q_pop      (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  assign busy = q_full;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import pfc_pkg::*;

  localparam opcode_t OPC_SPARE_LO = opcode_t'(5);
  localparam opcode_t OPC_SPARE_HI = opcode_t'(7);
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_WORDS = 800;

  localparam out_word_t ZERO_WORD = '0;
  localparam out_word_t NOT_READY = '{first_out: '0, second_out: '0, status: 1'b1};

  typedef struct packed {
    in_word_t  w;
    logic      typed;
    out_word_t want;
  } script_row_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_word_t  in_data = '0;
  logic      busy;
  logic      out_strobe;
  out_word_t out_data;

  // predictor copy of the key square
  letter_t       square [CELLS];
  int            cell_of [ALPHABET];
  logic [25:0]   placed = '0;
  int            filled = 0;
  logic          ready = 1'b0;

  out_word_t     due_words [$];
  out_word_t     oldest;
  int            accepted = 0;
  int            errors = 0;
  bit            no_gaps = 1'b0;
  bit            start_up = 1'b0;

  script_row_t script [0:DIRECTED_ROWS-1] = '{
    '{'{OPC_ENCRYPT, 5'd0, 5'd1}, 1'b1, NOT_READY},
    '{'{OPC_DECRYPT, 5'd31, 5'd31}, 1'b1, NOT_READY},
    '{'{OPC_SPARE_LO, 5'd31, 5'd0}, 1'b1, ZERO_WORD},
    '{'{OPC_SPARE_HI, 5'd31, 5'd31}, 1'b1, ZERO_WORD},
    '{'{OPC_KEY, 5'd15, 5'd31}, 1'b1, ZERO_WORD},
    '{'{OPC_KEY, 5'd11, 5'd0}, 1'b1, ZERO_WORD},
    '{'{OPC_KEY, 5'd0, 5'd0}, 1'b1, ZERO_WORD},
    '{'{OPC_KEY, 5'd24, 5'd0}, 1'b1, ZERO_WORD},
    '{'{OPC_KEY, 5'd5, 5'd0}, 1'b1, ZERO_WORD},
    '{'{OPC_KEY, 5'd0, 5'd0}, 1'b1, ZERO_WORD},
    '{'{OPC_KEY, LETTER_J, 5'd0}, 1'b1, ZERO_WORD},
    '{'{OPC_KEY, 5'd17, 5'd0}, 1'b1, ZERO_WORD},
    '{'{OPC_KEY, 5'd31, 5'd0}, 1'b1, ZERO_WORD},
    '{'{OPC_KEY, LETTER_I, 5'd0}, 1'b1, ZERO_WORD},
    '{'{OPC_FINISH, 5'd0, 5'd0}, 1'b1, ZERO_WORD},
    '{'{OPC_FINISH, 5'd31, 5'd31}, 1'b1, ZERO_WORD},
    '{'{OPC_KEY, 5'd1, 5'd0}, 1'b1, ZERO_WORD},
    '{'{OPC_ENCRYPT, 5'd15, 5'd11}, 1'b0, ZERO_WORD},
    '{'{OPC_ENCRYPT, 5'd15, LETTER_I}, 1'b0, ZERO_WORD},
    '{'{OPC_DECRYPT, 5'd2, 5'd25}, 1'b0, ZERO_WORD},
    '{'{OPC_ENCRYPT, LETTER_J, 5'd31}, 1'b0, ZERO_WORD},
    '{'{OPC_DECRYPT, 5'd0, 5'd0}, 1'b0, ZERO_WORD},
    '{'{OPC_ENCRYPT, 5'd31, 5'd16}, 1'b0, ZERO_WORD},
    '{'{OPC_CLEAR, 5'd31, 5'd31}, 1'b1, ZERO_WORD},
    '{'{OPC_DECRYPT, 5'd3, 5'd4}, 1'b1, NOT_READY}
  };

  playfair_digraph_cipher_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic letter_t fold_letter(letter_t raw);
    letter_t v;
    v = raw;
    if (v > LETTER_Z) begin
      v = LETTER_Z;
    end
    if (v == LETTER_J) begin
      v = LETTER_I;
    end
    return v;
  endfunction

  function automatic void place(letter_t l);
    if (!placed[l] && filled < CELLS) begin
      square[filled] = l;
      cell_of[l] = filled;
      placed[l] = 1'b1;
      filled++;
    end
  endfunction

  function automatic out_word_t playfair_predict(in_word_t w);
    out_word_t r;
    letter_t a, b;
    int ra, ca, rb, cb, shift;
    r = '0;
    a = fold_letter(w.first_letter);
    b = fold_letter(w.second_letter);
    case (w.opcode)
      OPC_CLEAR: begin
        placed = '0;
        filled = 0;
        ready = 1'b0;
      end
      OPC_KEY: begin
        if (!ready) begin
          place(a);
        end
      end
      OPC_FINISH: begin
        for (int k = 0; k < ALPHABET; k++) begin
          if (letter_t'(k) != LETTER_J) begin
            place(letter_t'(k));
          end
        end
        ready = 1'b1;
      end
      OPC_ENCRYPT, OPC_DECRYPT: begin
        if (!ready) begin
          r.status = 1'b1;
        end else begin
          shift = (w.opcode == OPC_ENCRYPT) ? 1 : SIDE - 1;
          ra = cell_of[a] / SIDE;
          ca = cell_of[a] % SIDE;
          rb = cell_of[b] / SIDE;
          cb = cell_of[b] % SIDE;
          if (ra == rb) begin
            r.first_out = square[ra * SIDE + (ca + shift) % SIDE];
            r.second_out = square[rb * SIDE + (cb + shift) % SIDE];
          end else if (ca == cb) begin
            r.first_out = square[((ra + shift) % SIDE) * SIDE + ca];
            r.second_out = square[((rb + shift) % SIDE) * SIDE + cb];
          end else begin
            r.first_out = square[ra * SIDE + cb];
            r.second_out = square[rb * SIDE + ca];
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic in_word_t word_of(opcode_t op, letter_t a, letter_t b);
    in_word_t w;
    w.opcode = op;
    w.first_letter = a;
    w.second_letter = b;
    return w;
  endfunction

  function automatic letter_t any_letter();
    if ($urandom_range(9) == 0) begin
      return letter_t'($urandom_range(31, 26));
    end
    return letter_t'($urandom_range(25));
  endfunction

  function automatic opcode_t pair_op();
    return $urandom_range(1) ? OPC_ENCRYPT : OPC_DECRYPT;
  endfunction

  function automatic int idle_cycles();
    int r;
    if (no_gaps) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(30, 5);
  endfunction

  task automatic push_word(in_word_t w, bit typed = 1'b0, out_word_t want = '0);
    out_word_t predicted;
    int n;
    in_data <= w;
    start <= 1'b1;
    start_up = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = playfair_predict(w);
    due_words.push_back(typed ? want : predicted);
    accepted++;
    n = idle_cycles();
    if (n > 0) begin
      start <= 1'b0;
      start_up = 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every outstanding word is back
  task automatic quiesce();
    if (start_up) begin
      start <= 1'b0;
      start_up = 1'b0;
    end
    @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
  endtask

  task automatic run_session();
    letter_t deck [CELLS];
    letter_t tmp, a;
    int kind, idx, pick;
    no_gaps = ($urandom_range(4) == 0);
    kind = $urandom_range(19);
    if (kind < 2) begin
      repeat ($urandom_range(6, 1)) begin
        push_word(word_of(opcode_t'($urandom_range(7)), letter_t'($urandom_range(31)),
                          letter_t'($urandom_range(31))));
      end
    end else if (kind < 4) begin
      // pairs against an unfinished square
      push_word(word_of(OPC_CLEAR, any_letter(), any_letter()));
      repeat ($urandom_range(6)) push_word(word_of(OPC_KEY, any_letter(), any_letter()));
      repeat ($urandom_range(6, 1)) push_word(word_of(pair_op(), any_letter(), any_letter()));
    end else begin
      push_word(word_of(OPC_CLEAR, any_letter(), any_letter()));
      if ($urandom_range(7) == 0) begin
        // whole alphabet as key, then letters beyond a full square
        idx = 0;
        for (int k = 0; k < ALPHABET; k++) begin
          if (letter_t'(k) != LETTER_J) begin
            deck[idx] = letter_t'(k);
            idx++;
          end
        end
        for (int k = CELLS - 1; k > 0; k--) begin
          pick = $urandom_range(k);
          tmp = deck[k];
          deck[k] = deck[pick];
          deck[pick] = tmp;
        end
        for (int k = 0; k < CELLS; k++) begin
          push_word(word_of(OPC_KEY, deck[k], any_letter()));
        end
        repeat ($urandom_range(3, 1)) push_word(word_of(OPC_KEY, any_letter(), any_letter()));
      end else begin
        repeat ($urandom_range(12)) begin
          if ($urandom_range(15) == 0) begin
            push_word(word_of(opcode_t'($urandom_range(OPC_SPARE_HI, OPC_SPARE_LO)),
                              any_letter(), any_letter()));
          end else begin
            push_word(word_of(OPC_KEY, any_letter(), any_letter()));
          end
        end
      end
      push_word(word_of(OPC_FINISH, any_letter(), any_letter()));
      if ($urandom_range(5) == 0) begin
        push_word(word_of(OPC_FINISH, any_letter(), any_letter()));
      end
      repeat ($urandom_range(40, 8)) begin
        if ($urandom_range(30) == 0) begin
          push_word(word_of(OPC_KEY, any_letter(), any_letter()));
        end else begin
          a = any_letter();
          push_word(word_of(pair_op(), a, ($urandom_range(7) == 0) ? a : any_letter()));
        end
      end
    end
    if ($urandom_range(5) == 0) begin
      quiesce();
    end
  endtask

  task automatic report_mismatch(string field, int want, int got);
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (due_words.size() == 0) begin
        $display("%0t: result word expected none actual %h", $time, out_data);
        errors++;
      end else begin
        oldest = due_words.pop_front();
        if (out_data.first_out !== oldest.first_out) begin
          report_mismatch("first_out", oldest.first_out, out_data.first_out);
        end
        if (out_data.second_out !== oldest.second_out) begin
          report_mismatch("second_out", oldest.second_out, out_data.second_out);
        end
        if (out_data.status !== oldest.status) begin
          report_mismatch("status", oldest.status, out_data.status);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      push_word(script[k].w, script[k].typed, script[k].want);
    end
    quiesce();
    while (accepted < DIRECTED_ROWS + RANDOM_WORDS) begin
      run_session();
    end
    quiesce();
    repeat (40) @(posedge clk);
    if (errors == 0 && due_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
